FILE: hw/rtl/multichannel_first_order_lowpass_unit_assert.svh
// Assertion macros used by the top-level RTL of the low-pass unit.
// They expect signals named clk and arst_n in the scope where they are used.
`ifndef MULTICHANNEL_FIRST_ORDER_LOWPASS_UNIT_ASSERT_SVH
`define MULTICHANNEL_FIRST_ORDER_LOWPASS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFLU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFLU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/mflu_pkg.sv
`default_nettype none
package mflu_pkg;

	localparam int NUM_CHANNELS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam int CH_W = 4;
	localparam int SAMPLE_W = 32;
	localparam int TAU_W = 16;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [TAU_W-1:0] TAU_RESET = 16'd100;

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_TAU = 1'b1;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} mem_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mflu_div.sv
`default_nettype none
module mflu_div #(
	parameter int FRAC_BITS = mflu_pkg::FRAC_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire [mflu_pkg::TAU_W-1:0]      numer,
	input  wire [mflu_pkg::TAU_W:0]        denom,
	output logic [FRAC_BITS-1:0]           quotient,
	output mflu_pkg::div_stat_t            stat
);
	import mflu_pkg::*;

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic [TAU_W:0]       rem_q;
	logic [TAU_W:0]       den_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TAU_W+1:0]     shifted;
	logic [TAU_W+1:0]     diff;
	logic                 fits;

	// The numerator is below the divisor, so each step yields one fraction bit.
	always_comb begin
		shifted = {rem_q, 1'b0};
		diff = shifted - {1'b0, den_q};
		fits = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, numer};
			den_q <= denom;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TAU_W:0] : shifted[TAU_W:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

FILE: hw/rtl/mflu_mem.sv
`default_nettype none
module mflu_mem #(
	parameter int NUM_CHANNELS = mflu_pkg::NUM_CHANNELS_DEF,
	parameter int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  mflu_pkg::mem_cmd_t                cmd,
	input  wire [IDX_W-1:0]                   addr,
	input  wire [mflu_pkg::SAMPLE_W-1:0]      wr_data,
	output logic [mflu_pkg::SAMPLE_W-1:0]     rd_data
);
	import mflu_pkg::*;

	logic [SAMPLE_W-1:0]     mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] valid_q;
	logic [SAMPLE_W-1:0]     rd_data_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				valid_q <= '0;
			end else if (cmd.wr) begin
				valid_q[addr] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[addr];
		end
	end

	// An entry never written since the last clear reads as zero.
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire

FILE: hw/rtl/multichannel_first_order_lowpass_unit.sv
// Per-channel first-order low-pass filter on signed Q16.16 samples. Each sample beat names a
// channel and the interval since that channel's last sample; the unit forms the weight
// interval / (time constant + interval) with FRAC_BITS fraction bits, moves the channel's stored
// value toward the sample by that weight and returns the new value. A channel at or above
// NUM_CHANNELS, or any sample while the filter is disabled, is returned unchanged; disabling the
// filter clears all stored values. One sample is handled at a time, passing through the restoring
// divider, which produces one weight bit per cycle, and then the multiply and add states; a finished
// result waits in the output register without holding up the start of the next sample, except that
// the add state stalls while the previous result is still untaken. Registers: filter_enable at byte
// address 0, time_constant_ms at byte address 4 (a write of zero is ignored).
`default_nettype none
`include "multichannel_first_order_lowpass_unit_assert.svh"
module multichannel_first_order_lowpass_unit #(
	parameter int NUM_CHANNELS = mflu_pkg::NUM_CHANNELS_DEF,
	parameter int FRAC_BITS = mflu_pkg::FRAC_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  sample_valid,
	output logic                                 sample_ready,
	input  wire [mflu_pkg::CH_W-1:0]             channel,
	input  wire signed [mflu_pkg::SAMPLE_W-1:0]  sample,
	input  wire [mflu_pkg::TAU_W-1:0]            interval_ms,
	output logic                                 result_valid,
	input  wire                                  result_ready,
	output logic [mflu_pkg::CH_W-1:0]            out_channel,
	output logic signed [mflu_pkg::SAMPLE_W-1:0] filtered,
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire [mflu_pkg::APB_ADDR_W-1:0]       paddr,
	input  wire [mflu_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [mflu_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);
	import mflu_pkg::*;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_MUL = 2'd2;
	localparam logic [1:0] ST_ADD = 2'd3;

	logic [1:0]                 state_q;
	logic                       enable_q;
	logic [TAU_W-1:0]           tau_q;
	logic                       cfg_wr;
	logic                       accept;
	logic                       finish;

	logic [CH_W-1:0]            ch_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       range_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic                       result_valid_q;
	logic [CH_W-1:0]            out_channel_q;
	logic [SAMPLE_W-1:0]        filtered_q;

	logic [FRAC_BITS-1:0]       alpha;
	div_stat_t                  div_stat;
	mem_cmd_t                   mem_cmd;
	logic [IDX_W-1:0]           mem_addr;
	logic [SAMPLE_W-1:0]        prev;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   scaled;
	logic [SAMPLE_W-1:0]        next;
	logic                       update;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_ENABLE: prdata[0] = enable_q;
			REG_TAU: prdata[TAU_W-1:0] = tau_q;
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			tau_q <= TAU_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ENABLE: enable_q <= pwdata[0];
				REG_TAU: begin
					if (pwdata[TAU_W-1:0] != '0) begin
						tau_q <= pwdata[TAU_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign accept = sample_valid && sample_ready;
	assign finish = (state_q == ST_ADD) && (!result_valid_q || result_ready);
	assign update = enable_q && range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= channel;
			sample_q <= sample;
			range_q <= (32'(channel) < 32'(NUM_CHANNELS));
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod;
		end
		if (finish) begin
			out_channel_q <= ch_q;
			filtered_q <= update ? next : sample_q;
		end
	end

	always_comb begin
		diff = {sample_q[SAMPLE_W-1], sample_q} - {prev[SAMPLE_W-1], prev};
		prod = diff * $signed({1'b0, alpha});
		scaled = prod_q >>> FRAC_BITS;
		next = prev + scaled[SAMPLE_W-1:0];
	end

	assign mem_addr = accept ? IDX_W'(channel) : IDX_W'(ch_q);
	assign mem_cmd.rd = accept;
	assign mem_cmd.wr = finish && update;
	assign mem_cmd.clr = cfg_wr && (paddr[2] == REG_ENABLE) && !pwdata[0];

	mflu_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.numer(interval_ms),
		.denom({1'b0, tau_q} + {1'b0, interval_ms}),
		.quotient(alpha),
		.stat(div_stat)
	);

	mflu_mem #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.IDX_W(IDX_W)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(mem_cmd),
		.addr(mem_addr),
		.wr_data(next),
		.rd_data(prev)
	);

	assign result_valid = result_valid_q;
	assign out_channel = out_channel_q;
	assign filtered = filtered_q;

	`MFLU_ASSERT_NXT(a_busy_after_accept, accept, !sample_ready, "unit ready right after a beat")
	`MFLU_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == ST_DIV, "divider done outside wait")
	`MFLU_ASSERT_IMP(a_div_busy_in_div, div_stat.busy, state_q == ST_DIV, "divider busy outside wait")
	`MFLU_ASSERT_IMP(a_tau_nonzero, 1'b1, tau_q != '0, "time constant is zero")
	`MFLU_ASSERT_IMP(a_result_from_add, $rose(result_valid), $past(state_q == ST_ADD), "stray result")

endmodule
`default_nettype wire

FILE: tb/sv/multichannel_first_order_lowpass_unit_tb.sv
`timescale 1ns / 1ps
module multichannel_first_order_lowpass_unit_tb;
	import mflu_pkg::*;

	localparam int NCH = NUM_CHANNELS_DEF;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam logic [APB_ADDR_W-1:0] ADDR_ENABLE = APB_ADDR_W'(4 * int'(REG_ENABLE));
	localparam logic [APB_ADDR_W-1:0] ADDR_TAU = APB_ADDR_W'(4 * int'(REG_TAU));
	localparam logic signed [SAMPLE_W-1:0] MAX_SAMPLE = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] MIN_SAMPLE = 32'sh8000_0000;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic signed [SAMPLE_W-1:0] value;
	} lp_result_t;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	logic [CH_W-1:0] channel;
	logic signed [SAMPLE_W-1:0] sample;
	logic [TAU_W-1:0] interval_ms;
	logic result_valid;
	logic result_ready;
	logic [CH_W-1:0] out_channel;
	logic signed [SAMPLE_W-1:0] filtered;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	logic signed [SAMPLE_W-1:0] chan_value [NCH];
	logic filter_on;
	logic [TAU_W-1:0] tau_ms;
	lp_result_t pending_q[$];
	int fail_count;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	multichannel_first_order_lowpass_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.channel(channel),
		.sample(sample),
		.interval_ms(interval_ms),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_channel(out_channel),
		.filtered(filtered),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Moves ch's value toward smp, returns it; if off, clears all, returns smp.
	function automatic logic signed [SAMPLE_W-1:0] lowpass_update(
		input logic [CH_W-1:0] ch,
		input logic signed [SAMPLE_W-1:0] smp,
		input logic [TAU_W-1:0] iv
	);
		longint weight;
		longint prev;
		longint delta;
		longint next_val;
		if (!filter_on) begin
			foreach (chan_value[i]) chan_value[i] = '0;
			return smp;
		end
		weight = (longint'(iv) << FRAC) / (longint'(tau_ms) + longint'(iv));
		prev = longint'(chan_value[ch]);
		delta = longint'(smp) - prev;
		next_val = prev + ((delta * weight) >>> FRAC);
		chan_value[ch] = SAMPLE_W'(next_val);
		return SAMPLE_W'(next_val);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return MAX_SAMPLE;
			1: return MIN_SAMPLE;
			2, 3: return SAMPLE_W'(int'($urandom_range(1 << 21)) - (1 << 20));
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [TAU_W-1:0] rand_interval();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return TAU_W'($urandom_range(400));
			default: return TAU_W'($urandom_range(65535));
		endcase
	endfunction

	function automatic logic [TAU_W-1:0] rand_tau();
		case ($urandom_range(5))
			0: return 16'd1;
			1: return 16'hFFFF;
			2, 3: return TAU_W'($urandom_range(1, 2000));
			default: return TAU_W'($urandom_range(1, 65535));
		endcase
	endfunction

	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		lp_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result beat on channel %0d, filtered %0d", out_channel,
					filtered);
				fail_count++;
			end else begin
				want = pending_q.pop_front();
				if (out_channel !== want.ch) begin
					$error("out_channel: expected %0d, got %0d", want.ch, out_channel);
					fail_count++;
				end
				if (filtered !== want.value) begin
					$error("filtered: expected %0d, got %0d", want.value, filtered);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready)
			|| (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("multichannel_first_order_lowpass_unit_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic send_sample(
		input logic [CH_W-1:0] ch,
		input logic signed [SAMPLE_W-1:0] smp,
		input logic [TAU_W-1:0] iv
	);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		channel <= ch;
		sample <= smp;
		interval_ms <= iv;
		do @(posedge clk); while (!sample_ready);
		pending_q.push_back('{ch: ch, value: lowpass_update(ch, smp, iv)});
	endtask

	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_ENABLE) begin
			filter_on = data[0];
			if (!filter_on) foreach (chan_value[i]) chan_value[i] = '0;
		end else if (addr == ADDR_TAU && data[TAU_W-1:0] != '0) begin
			tau_ms = data[TAU_W-1:0];
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] want,
		input logic [APB_DATA_W-1:0] mask);
		logic [APB_DATA_W-1:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata & mask;
		if (got !== (want & mask)) begin
			$error("prdata: expected %0d, got %0d", want & mask, got);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Holds the sender back until every outstanding result beat has been taken.
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_register_access();
		check_reg(ADDR_ENABLE, 32'd1, 32'h1);
		check_reg(ADDR_TAU, 32'd100, 32'hFFFF);
		write_reg(ADDR_TAU, 32'd0);
		check_reg(ADDR_TAU, 32'd100, 32'hFFFF);
		write_reg(ADDR_TAU, 32'd1);
		check_reg(ADDR_TAU, 32'd1, 32'hFFFF);
		write_reg(ADDR_TAU, 32'hFFFF_FFFF);
		check_reg(ADDR_TAU, 32'hFFFF, 32'hFFFF);
		write_reg(ADDR_TAU, 32'd100);
	endtask

	task automatic test_directed_filtering();
		send_sample(4'd0, MAX_SAMPLE, 16'd100);
		send_sample(4'd0, MIN_SAMPLE, 16'hFFFF);
		send_sample(4'd0, 32'sh1234_5678, 16'd0);
		send_sample(4'd15, -32'sd1, 16'd100);
		send_sample(4'd15, 32'sd1, 16'd1);
		drain();
		write_reg(ADDR_TAU, 32'd1);
		send_sample(4'd1, MAX_SAMPLE, 16'hFFFF);
		send_sample(4'd1, MIN_SAMPLE, 16'hFFFF);
		send_sample(4'd2, 32'sh0001_0000, 16'd1);
		drain();
		write_reg(ADDR_TAU, 32'hFFFF);
		send_sample(4'd3, MAX_SAMPLE, 16'hFFFF);
		send_sample(4'd3, MIN_SAMPLE, 16'd1);
		send_sample(4'd3, 32'sd0, 16'd0);
		drain();
		write_reg(ADDR_TAU, 32'd100);
	endtask

	task automatic test_disable_passthrough();
		send_sample(4'd4, 32'sh0010_0000, 16'd300);
		send_sample(4'd5, MIN_SAMPLE, 16'd50);
		drain();
		write_reg(ADDR_ENABLE, 32'd0);
		check_reg(ADDR_ENABLE, 32'd0, 32'h1);
		send_sample(4'd4, 32'sh0005_0000, 16'd100);
		send_sample(4'd4, MIN_SAMPLE, 16'd0);
		send_sample(4'd5, MAX_SAMPLE, 16'hFFFF);
		drain();
		write_reg(ADDR_ENABLE, 32'd1);
		send_sample(4'd4, 32'sh0002_0000, 16'd100);
		send_sample(4'd5, -32'sh0002_0000, 16'd100);
		drain();
	endtask

	task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_reg(ADDR_TAU, 32'(rand_tau()));
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2) begin
				drain();
				write_reg(ADDR_TAU, 32'(rand_tau()));
			end
			send_sample(CH_W'($urandom_range(NCH - 1)), rand_sample(), rand_interval());
		end
		drain();
	endtask

	task automatic test_random_disabled(input int n_items);
		write_reg(ADDR_ENABLE, 32'd0);
		for (int i = 0; i < n_items; i++)
			send_sample(CH_W'($urandom_range(NCH - 1)), rand_sample(), rand_interval());
		drain();
		write_reg(ADDR_ENABLE, 32'd1);
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		channel = '0;
		sample = '0;
		interval_ms = '0;
		result_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		filter_on = 1'b1;
		tau_ms = TAU_RESET;
		foreach (chan_value[i]) chan_value[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_access();
		test_directed_filtering();
		test_disable_passthrough();
		test_random_traffic(430, 0, 0);
		test_random_traffic(430, 70, 0);
		test_random_disabled(60);
		test_random_traffic(430, 0, 70);
		test_random_traffic(430, 13, 13);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_q.size() != 0) begin
			$error("%0d result beats never arrived", pending_q.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("multichannel_first_order_lowpass_unit_tb OK");
		end else begin
			$display("multichannel_first_order_lowpass_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mflu_pkg.sv
hw/rtl/mflu_div.sv
hw/rtl/mflu_mem.sv
hw/rtl/multichannel_first_order_lowpass_unit.sv
tb/sv/multichannel_first_order_lowpass_unit_tb.sv
